/* hdl/mslc_pkg.sv */
// shared constants, types and controller/datapath interface structs
// for the midpoint subdivision line clipper; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mslc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int SPAN_BITS   = COORD_BITS - 1;
  localparam int STACK_DEPTH = 16;
  localparam int MAX_PIECES  = 64;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_PIECES + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPAN  = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_POP_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;   // load a new segment, clear per-segment state
    logic split;   // push start half, continue with end half
    logic keep;    // retire held fragment to output, hold current piece
    logic pop;     // read the top of the stack
    logic load;    // current piece from stack read data
    logic limit;   // fragment limit reached
    logic finish;  // deliver the final result
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic visible;
    logic limit_hit;
    logic stack_empty;
    logic held_valid;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hdl/midpoint_subdivision_line_clipper.sv */
// top level of the midpoint subdivision line clipper
// joins mslc_ctrl and mslc_datapath; uses mslc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Clips one segment (signed Q9.6 endpoints) against the window held in the
// configuration registers by recursive midpoint subdivision, with the start
// halves waiting on a 16-entry stack in a ram. Each segment gives its visible
// fragments in subdivision order (end half before start half), or one empty
// marker with out_piece_valid low; the final result of a segment carries
// out_last_piece, and out_cut_short on it reports that the 64-fragment limit
// or a full stack threw work away. Timing is data dependent: the block takes
// the request, evaluates the pieces, spends an extra wait state on each piece
// taken back off the stack (the stack ram read is registered), delivers the
// final result, and waits while the output is stalled and a result waits for
// it. Subdivision depth is bounded by the coordinate width. A single
// evaluation unit handles one piece per cycle while no stack read or busy
// output holds it up, so one segment is in work at a time; the next segment
// is taken as soon as the last result of the previous one sits in the output
// register. Configuration writes take effect at once and belong in idle
// periods.

module midpoint_subdivision_line_clipper (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // configuration write port
  input  wire logic                                   cfg_we,
  input  wire logic [mslc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mslc_pkg::COORD_BITS-1:0]        cfg_data,
  // segment requests
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_start_x,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_start_y,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_end_x,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_end_y,
  // fragment results
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_x0,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_y0,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_x1,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_y1,
  output logic                                        out_piece_valid,
  output logic                                        out_last_piece,
  output logic                                        out_cut_short
);

  // command and status between controller and datapath
  mslc_pkg::cmd_t  cmd;
  mslc_pkg::stat_t stat;

  // sequencer: evaluate, split, pop, deliver
  mslc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // window registers, piece registers, stack and output register
  mslc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_piece_x0   (out_piece_x0),
    .out_piece_y0   (out_piece_y0),
    .out_piece_x1   (out_piece_x1),
    .out_piece_y1   (out_piece_y1),
    .out_piece_valid(out_piece_valid),
    .out_last_piece (out_last_piece),
    .out_cut_short  (out_cut_short)
  );

endmodule

`default_nettype wire

/* hdl/mslc_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mslc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/mslc_datapath.sv */
// clipper datapath: config registers, current and held pieces, outcodes,
// midpoint, stack ram, counters and output register; uses mslc_pkg, mslc_ram
`timescale 1ns / 1ps
`default_nettype none

module mslc_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [mslc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mslc_pkg::COORD_BITS-1:0]        cfg_data,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_start_x,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_start_y,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_end_x,
  input  wire logic signed [mslc_pkg::COORD_BITS-1:0] in_end_y,
  input  wire mslc_pkg::cmd_t                         cmd,
  output mslc_pkg::stat_t                             stat,
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_x0,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_y0,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_x1,
  output logic signed [mslc_pkg::COORD_BITS-1:0]      out_piece_y1,
  output logic                                        out_piece_valid,
  output logic                                        out_last_piece,
  output logic                                        out_cut_short
);

  localparam int W = mslc_pkg::COORD_BITS;

  localparam logic [3:0] OC_BOTTOM = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_TOP    = 4'b0100;
  localparam logic [3:0] OC_LEFT   = 4'b1000;

  // configuration
  logic signed [W-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;
  logic [mslc_pkg::SPAN_BITS-1:0] span_r;

  // per-segment state
  mslc_pkg::seg_t cur_r, cur_nxt, held_r, held_nxt;
  logic held_valid_r, held_valid_nxt;
  logic [mslc_pkg::TOP_W-1:0] top_r, top_nxt;
  logic [mslc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic cut_r, cut_nxt;

  // output register
  mslc_pkg::seg_t out_seg_r, out_seg_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_pv_r, out_pv_nxt;
  logic out_last_r, out_last_nxt;
  logic out_cut_r, out_cut_nxt;

  // evaluation
  logic signed [W:0] dx, dy, sx, sy;
  logic [W:0] adx, ady;
  logic [mslc_pkg::SPAN_BITS-1:0] tol;
  logic small_span;
  logic [3:0] code0, code1;
  logic stack_full, stack_empty, out_free;
  mslc_pkg::seg_t push_seg, mid_seg, pop_seg;
  logic push_we;

  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W-1:0] wl,
    input logic signed [W-1:0] wb,
    input logic signed [W-1:0] wr,
    input logic signed [W-1:0] wt
  );
    logic [3:0] c;
    c = '0;
    if (x <= wl) c = c | OC_LEFT;
    if (x >= wr) c = c | OC_RIGHT;
    if (y <= wb) c = c | OC_BOTTOM;
    if (y >= wt) c = c | OC_TOP;
    return c;
  endfunction

  always_comb begin
    dx  = {cur_r.ax[W-1], cur_r.ax} - {cur_r.bx[W-1], cur_r.bx};
    dy  = {cur_r.ay[W-1], cur_r.ay} - {cur_r.by[W-1], cur_r.by};
    adx = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
    ady = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
    tol = (span_r == '0) ? mslc_pkg::SPAN_BITS'(1) : span_r;
    small_span = (adx <= (W+1)'(tol)) && (ady <= (W+1)'(tol));

    code0 = outcode(cur_r.ax, cur_r.ay, win_left_r, win_bottom_r, win_right_r, win_top_r);
    code1 = outcode(cur_r.bx, cur_r.by, win_left_r, win_bottom_r, win_right_r, win_top_r);

    // floor midpoint is an arithmetic shift of the widened sum
    sx = {cur_r.ax[W-1], cur_r.ax} + {cur_r.bx[W-1], cur_r.bx};
    sy = {cur_r.ay[W-1], cur_r.ay} + {cur_r.by[W-1], cur_r.by};

    push_seg.ax = cur_r.ax;
    push_seg.ay = cur_r.ay;
    push_seg.bx = sx[W:1];
    push_seg.by = sy[W:1];
    mid_seg.ax  = sx[W:1];
    mid_seg.ay  = sy[W:1];
    mid_seg.bx  = cur_r.bx;
    mid_seg.by  = cur_r.by;

    stack_full  = (top_r == mslc_pkg::TOP_W'(mslc_pkg::STACK_DEPTH));
    stack_empty = (top_r == '0);
    out_free    = !out_valid_r || !out_stall;
    push_we     = cmd.split && !stack_full;
  end

  always_comb begin
    stat.visible     = (code0 == '0) && (code1 == '0) && !small_span;
    stat.drop        = small_span || (((code0 | code1) != '0) && ((code0 & code1) != '0));
    stat.limit_hit   = (cnt_r >= mslc_pkg::CNT_W'(mslc_pkg::MAX_PIECES));
    stat.stack_empty = stack_empty;
    stat.held_valid  = held_valid_r;
    stat.out_free    = out_free;
  end

  logic [mslc_pkg::TOP_W-1:0] top_dec;
  assign top_dec = top_r - mslc_pkg::TOP_W'(1);

  mslc_ram #(
    .WIDTH($bits(mslc_pkg::seg_t)),
    .DEPTH(mslc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (push_we),
    .waddr(top_r[mslc_pkg::STACK_AW-1:0]),
    .wdata(push_seg),
    .re   (cmd.pop),
    .raddr(top_dec[mslc_pkg::STACK_AW-1:0]),
    .rdata(pop_seg)
  );

  always_comb begin
    cur_nxt        = cur_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    top_nxt        = top_r;
    cnt_nxt        = cnt_r;
    cut_nxt        = cut_r;
    out_seg_nxt    = out_seg_r;
    out_pv_nxt     = out_pv_r;
    out_last_nxt   = out_last_r;
    out_cut_nxt    = out_cut_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cmd.start) begin
      cur_nxt.ax     = in_start_x;
      cur_nxt.ay     = in_start_y;
      cur_nxt.bx     = in_end_x;
      cur_nxt.by     = in_end_y;
      held_valid_nxt = 1'b0;
      top_nxt        = '0;
      cnt_nxt        = '0;
      cut_nxt        = 1'b0;
    end
    if (cmd.split) begin
      cur_nxt = mid_seg;
      if (stack_full) begin
        cut_nxt = 1'b1;
      end else begin
        top_nxt = top_r + mslc_pkg::TOP_W'(1);
      end
    end
    if (cmd.load) begin
      cur_nxt = pop_seg;
    end
    if (cmd.pop) begin
      top_nxt = top_dec;
    end
    if (cmd.limit) begin
      cut_nxt = 1'b1;
    end
    if (cmd.keep) begin
      if (held_valid_r) begin
        out_seg_nxt   = held_r;
        out_pv_nxt    = 1'b1;
        out_last_nxt  = 1'b0;
        out_cut_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
      end
      held_nxt       = cur_r;
      held_valid_nxt = 1'b1;
      cnt_nxt        = cnt_r + mslc_pkg::CNT_W'(1);
    end
    if (cmd.finish) begin
      // empty marker when no fragment was found
      out_seg_nxt   = held_valid_r ? held_r : '0;
      out_pv_nxt    = held_valid_r;
      out_last_nxt  = 1'b1;
      out_cut_nxt   = cut_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_bottom_r <= '0;
      win_right_r  <= W'(448);
      win_top_r    <= W'(384);
      span_r       <= mslc_pkg::SPAN_BITS'(6);
    end else if (cfg_we) begin
      case (cfg_index)
        mslc_pkg::CFG_WIN_LEFT:   win_left_r   <= cfg_data;
        mslc_pkg::CFG_WIN_BOTTOM: win_bottom_r <= cfg_data;
        mslc_pkg::CFG_WIN_RIGHT:  win_right_r  <= cfg_data;
        mslc_pkg::CFG_WIN_TOP:    win_top_r    <= cfg_data;
        mslc_pkg::CFG_STOP_SPAN:  span_r       <= cfg_data[mslc_pkg::SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      top_r        <= '0;
      cnt_r        <= '0;
      cut_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      top_r        <= top_nxt;
      cnt_r        <= cnt_nxt;
      cut_r        <= cut_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    held_r     <= held_nxt;
    out_seg_r  <= out_seg_nxt;
    out_pv_r   <= out_pv_nxt;
    out_last_r <= out_last_nxt;
    out_cut_r  <= out_cut_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_piece_x0    = out_seg_r.ax;
  assign out_piece_y0    = out_seg_r.ay;
  assign out_piece_x1    = out_seg_r.bx;
  assign out_piece_y1    = out_seg_r.by;
  assign out_piece_valid = out_pv_r;
  assign out_last_piece  = out_last_r;
  assign out_cut_short   = out_cut_r;

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= mslc_pkg::TOP_W'(mslc_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mslc_pkg::CNT_W'(mslc_pkg::MAX_PIECES))
    else $error("fragment count beyond limit");

  a_keep_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.keep && held_valid_r) |-> out_free)
    else $error("held fragment retired onto a busy output");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> out_free)
    else $error("final result onto a busy output");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stack_empty)
    else $error("pop from empty stack");

  a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (cnt_r != '0))
    else $error("held fragment without count");

endmodule

`default_nettype wire

/* hdl/mslc_ctrl.sv */
// clipper controller: state machine sequencing evaluate, split, pop and
// result delivery; uses mslc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mslc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire mslc_pkg::stat_t stat,
  output mslc_pkg::cmd_t       cmd
);

  mslc_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mslc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mslc_pkg::ST_EVAL;
      end
      mslc_pkg::ST_EVAL: begin
        if (stat.drop) begin
          state_nxt = stat.stack_empty ? mslc_pkg::ST_FINISH : mslc_pkg::ST_POP_WAIT;
        end else if (stat.visible) begin
          if (stat.limit_hit) begin
            state_nxt = mslc_pkg::ST_FINISH;
          end else if (!stat.held_valid || stat.out_free) begin
            state_nxt = stat.stack_empty ? mslc_pkg::ST_FINISH : mslc_pkg::ST_POP_WAIT;
          end
        end
      end
      mslc_pkg::ST_POP_WAIT: begin
        state_nxt = mslc_pkg::ST_EVAL;
      end
      mslc_pkg::ST_FINISH: begin
        if (stat.out_free) state_nxt = mslc_pkg::ST_IDLE;
      end
      default: state_nxt = mslc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      mslc_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      mslc_pkg::ST_EVAL: begin
        if (stat.drop) begin
          cmd.pop = !stat.stack_empty;
        end else if (stat.visible) begin
          if (stat.limit_hit) begin
            cmd.limit = 1'b1;
          end else if (!stat.held_valid || stat.out_free) begin
            cmd.keep = 1'b1;
            cmd.pop  = !stat.stack_empty;
          end
        end else begin
          cmd.split = 1'b1;
        end
      end
      mslc_pkg::ST_POP_WAIT: begin
        cmd.load = 1'b1;
      end
      mslc_pkg::ST_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mslc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == mslc_pkg::ST_EVAL))
    else $error("segment start did not enter evaluation");

  a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $past(cmd.pop))
    else $error("stack load without preceding pop");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.split, cmd.keep, cmd.limit, cmd.load, cmd.finish, cmd.start}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

/* tb/midpoint_subdivision_line_clipper_tb.sv */
// self-checking testbench for midpoint_subdivision_line_clipper
// predicts every clipped fragment with its own subdivision model; needs mslc_pkg and the rtl
`timescale 1ns / 1ps

module midpoint_subdivision_line_clipper_tb;

  // run limits
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int COORD_MIN     = -32768;
  localparam int COORD_MAX     = 32767;

  // outcode bits, set independently per edge
  localparam logic [3:0] OC_BOTTOM = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_TOP    = 4'd4;
  localparam logic [3:0] OC_LEFT   = 4'd8;
  localparam logic [3:0] OC_NONE   = 4'd0;

  // one result as the block should deliver it
  typedef struct packed {
    logic signed [mslc_pkg::COORD_BITS-1:0] x0;
    logic signed [mslc_pkg::COORD_BITS-1:0] y0;
    logic signed [mslc_pkg::COORD_BITS-1:0] x1;
    logic signed [mslc_pkg::COORD_BITS-1:0] y1;
    logic                                   vld;
    logic                                   last;
    logic                                   cut;
  } piece_t;

  // every input is known from time zero
  logic                                   clk        = 1'b0;
  logic                                   rst_n      = 1'b0;
  logic                                   cfg_we     = 1'b0;
  logic [mslc_pkg::CFG_IDX_W-1:0]         cfg_index  = '0;
  logic [mslc_pkg::COORD_BITS-1:0]        cfg_data   = '0;
  logic                                   in_valid   = 1'b0;
  logic                                   in_stall;
  logic signed [mslc_pkg::COORD_BITS-1:0] in_start_x = '0;
  logic signed [mslc_pkg::COORD_BITS-1:0] in_start_y = '0;
  logic signed [mslc_pkg::COORD_BITS-1:0] in_end_x   = '0;
  logic signed [mslc_pkg::COORD_BITS-1:0] in_end_y   = '0;
  logic                                   out_valid;
  logic                                   out_stall  = 1'b0;
  logic signed [mslc_pkg::COORD_BITS-1:0] out_piece_x0;
  logic signed [mslc_pkg::COORD_BITS-1:0] out_piece_y0;
  logic signed [mslc_pkg::COORD_BITS-1:0] out_piece_x1;
  logic signed [mslc_pkg::COORD_BITS-1:0] out_piece_y1;
  logic                                   out_piece_valid;
  logic                                   out_last_piece;
  logic                                   out_cut_short;

  // shadow of the window registers, starting at their reset values
  logic signed [mslc_pkg::COORD_BITS-1:0] win_left_q   = 16'sd0;
  logic signed [mslc_pkg::COORD_BITS-1:0] win_bottom_q = 16'sd0;
  logic signed [mslc_pkg::COORD_BITS-1:0] win_right_q  = 16'sd448;
  logic signed [mslc_pkg::COORD_BITS-1:0] win_top_q    = 16'sd384;
  logic [mslc_pkg::SPAN_BITS-1:0]         stop_span_q  = 15'd6;

  // fragments still owed by the block, oldest first
  piece_t awaited_pieces[$];

  // idling switches and bookkeeping
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int errors        = 0;
  int segments_sent = 0;
  int windows_set   = 0;
  int writes_done   = 0;
  int results_seen  = 0;
  int fragments_seen = 0;
  int markers_seen  = 0;
  int cuts_seen     = 0;
  int stall_left    = 0;
  int cycle_count   = 0;

  midpoint_subdivision_line_clipper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_piece_x0    (out_piece_x0),
    .out_piece_y0    (out_piece_y0),
    .out_piece_x1    (out_piece_x1),
    .out_piece_y1    (out_piece_y1),
    .out_piece_valid (out_piece_valid),
    .out_last_piece  (out_last_piece),
    .out_cut_short   (out_cut_short)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed", $time, cycle_count,
               awaited_pieces.size());
      $display("midpoint_subdivision_line_clipper_tb NOT OK");
      $finish;
    end
  end

  // receiver back-pressure: random bursts of stalled cycles
  always @(posedge clk) begin
    if (!rst_n || !stalls_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int span_of(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // edge tests are inclusive: a point on an edge counts as outside
  function automatic logic [3:0] outcode(input int x, input int y);
    logic [3:0] code;
    code = OC_NONE;
    if (x <= int'(win_left_q))   code |= OC_LEFT;
    if (x >= int'(win_right_q))  code |= OC_RIGHT;
    if (y <= int'(win_bottom_q)) code |= OC_BOTTOM;
    if (y >= int'(win_top_q))    code |= OC_TOP;
    return code;
  endfunction

  function automatic mslc_pkg::seg_t make_seg(input int ax, input int ay, input int bx,
                                              input int by);
    mslc_pkg::seg_t s;
    s.ax = ax[mslc_pkg::COORD_BITS-1:0];
    s.ay = ay[mslc_pkg::COORD_BITS-1:0];
    s.bx = bx[mslc_pkg::COORD_BITS-1:0];
    s.by = by[mslc_pkg::COORD_BITS-1:0];
    return s;
  endfunction

  // walks the subdivision tree of one segment and queues the fragments it yields
  function automatic void clip_segment(input mslc_pkg::seg_t seg);
    mslc_pkg::seg_t held [mslc_pkg::STACK_DEPTH];
    mslc_pkg::seg_t cur;
    piece_t         found [$];
    piece_t         pc;
    int             depth, tol, ax, ay, bx, by, mx, my;
    logic [3:0]     c0, c1;
    logic           cut, busy, split, stop;
    depth = 0;
    // a zero tolerance behaves as one, else one-unit spans never settle
    tol   = (stop_span_q == '0) ? 1 : int'(stop_span_q);
    cut   = 1'b0;
    busy  = 1'b1;
    cur   = seg;
    while (busy) begin
      ax    = cur.ax;
      ay    = cur.ay;
      bx    = cur.bx;
      by    = cur.by;
      split = 1'b0;
      stop  = 1'b0;
      // pieces within tolerance on both axes are simply dropped
      if (span_of(ax, bx) > tol || span_of(ay, by) > tol) begin
        c0 = outcode(ax, ay);
        c1 = outcode(bx, by);
        if ((c0 | c1) == OC_NONE) begin
          if (found.size() >= mslc_pkg::MAX_PIECES) begin
            // fragment limit: this one and all pending work are thrown away
            cut  = 1'b1;
            stop = 1'b1;
          end else begin
            pc      = '0;
            pc.x0   = cur.ax;
            pc.y0   = cur.ay;
            pc.x1   = cur.bx;
            pc.y1   = cur.by;
            pc.vld  = 1'b1;
            found.push_back(pc);
          end
        end else if ((c0 & c1) == OC_NONE) begin
          // floor midpoint; start half waits, end half goes on
          mx = (ax + bx) >>> 1;
          my = (ay + by) >>> 1;
          if (depth < mslc_pkg::STACK_DEPTH) begin
            held[depth] = make_seg(ax, ay, mx, my);
            depth++;
          end else begin
            // stack full: the start half is lost
            cut = 1'b1;
          end
          cur   = make_seg(mx, my, bx, by);
          split = 1'b1;
        end
      end
      if (stop) begin
        busy = 1'b0;
      end else if (!split) begin
        if (depth > 0) begin
          depth--;
          cur = held[depth];
        end else begin
          busy = 1'b0;
        end
      end
    end
    // nothing visible: a single empty marker
    if (found.size() == 0) found.push_back(piece_t'('0));
    pc      = found.pop_back();
    pc.last = 1'b1;
    pc.cut  = cut;
    found.push_back(pc);
    foreach (found[i]) awaited_pieces.push_back(found[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: result %0d %s expected %0d, got %0d", $time, results_seen, name, want,
               got);
    end
  endtask

  // each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    piece_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_pieces.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: expected none, got (%0d,%0d)-(%0d,%0d) v%0b",
                 $time, out_piece_x0, out_piece_y0, out_piece_x1, out_piece_y1,
                 out_piece_valid);
      end else begin
        want = awaited_pieces.pop_front();
        check_field("piece_x0", want.x0, out_piece_x0);
        check_field("piece_y0", want.y0, out_piece_y0);
        check_field("piece_x1", want.x1, out_piece_x1);
        check_field("piece_y1", want.y1, out_piece_y1);
        check_field("piece_valid", want.vld, out_piece_valid);
        check_field("last_piece", want.last, out_last_piece);
        check_field("cut_short", want.cut, out_cut_short);
        if (want.vld) fragments_seen++;
        else markers_seen++;
        if (want.cut) cuts_seen++;
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one segment request; accepted at the edge where valid is high and stall low
  task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= sx[mslc_pkg::COORD_BITS-1:0];
    in_start_y <= sy[mslc_pkg::COORD_BITS-1:0];
    in_end_x   <= ex[mslc_pkg::COORD_BITS-1:0];
    in_end_y   <= ey[mslc_pkg::COORD_BITS-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_segment(make_seg(sx, sy, ex, ey));
    segments_sent++;
  endtask

  // sender holds off until every owed result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_pieces.size() != 0);
  endtask

  task automatic write_reg(input logic [mslc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mslc_pkg::COORD_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      mslc_pkg::CFG_WIN_LEFT:   win_left_q   = value;
      mslc_pkg::CFG_WIN_BOTTOM: win_bottom_q = value;
      mslc_pkg::CFG_WIN_RIGHT:  win_right_q  = value;
      mslc_pkg::CFG_WIN_TOP:    win_top_q    = value;
      mslc_pkg::CFG_STOP_SPAN:  stop_span_q  = value[mslc_pkg::SPAN_BITS-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // registers change only with the block idle
  task automatic program_window(input int l, input int b, input int r, input int t,
                                input int span);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(mslc_pkg::CFG_WIN_LEFT, l[mslc_pkg::COORD_BITS-1:0]);
    write_reg(mslc_pkg::CFG_WIN_BOTTOM, b[mslc_pkg::COORD_BITS-1:0]);
    write_reg(mslc_pkg::CFG_WIN_RIGHT, r[mslc_pkg::COORD_BITS-1:0]);
    write_reg(mslc_pkg::CFG_WIN_TOP, t[mslc_pkg::COORD_BITS-1:0]);
    write_reg(mslc_pkg::CFG_STOP_SPAN, span[mslc_pkg::COORD_BITS-1:0]);
    cfg_we <= 1'b0;
    windows_set++;
  endtask

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int pick_near(input int lo, input int hi, input int margin);
    int a, b;
    a = clamp_coord(((lo < hi) ? lo : hi) - margin);
    b = clamp_coord(((lo < hi) ? hi : lo) + margin);
    return a + int'($urandom_range(0, b - a));
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) + COORD_MIN;
  endfunction

  // mostly segments around the current window, some pure noise
  task automatic send_random_segment();
    int lx, hx, ly, hy, mx, my;
    lx = win_left_q;
    hx = win_right_q;
    ly = win_bottom_q;
    hy = win_top_q;
    mx = span_of(lx, hx) / 2 + int'($urandom_range(8, 256));
    my = span_of(ly, hy) / 2 + int'($urandom_range(8, 256));
    case ($urandom_range(0, 9))
      0, 1: send_segment(any_coord(), any_coord(), any_coord(), any_coord());
      2: send_segment(pick_near(lx, hx, 8192), pick_near(ly, hy, 8192),
                      pick_near(lx, hx, 8192), pick_near(ly, hy, 8192));
      default: send_segment(pick_near(lx, hx, mx), pick_near(ly, hy, my),
                            pick_near(lx, hx, mx), pick_near(ly, hy, my));
    endcase
  endtask

  task automatic random_window();
    int l, b, r, t, span, swap;
    l = int'($urandom_range(0, 50000)) - 25000;
    b = int'($urandom_range(0, 50000)) - 25000;
    r = clamp_coord(l + int'($urandom_range(32, 12000)));
    t = clamp_coord(b + int'($urandom_range(32, 12000)));
    // now and then an inverted window
    if ($urandom_range(0, 7) == 0) begin
      swap = l;
      l    = r;
      r    = swap;
    end
    case ($urandom_range(0, 7))
      0:       span = 0;
      1:       span = $urandom_range(256, 32767);
      2:       span = 1;
      default: span = $urandom_range(2, 24);
    endcase
    program_window(l, b, r, t, span);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset window 0..448 x 0..384, tolerance 6
  task automatic test_default_window();
    send_segment(64, 64, 384, 320);              // wholly inside
    send_segment(-500, 10, -100, 300);           // wholly left, trivial reject
    send_segment(-200, 100, 200, 200);           // crosses the left edge
    send_segment(-1000, 192, 1500, 192);         // crosses left and right
    send_segment(200, -32768, 200, 32767);       // crosses bottom and top
    send_segment(-32768, -32768, 32767, 32767);  // corner to corner, full range
    send_segment(32767, 32767, -32768, -32768);  // same, reversed
    send_segment(-32768, 32767, 32767, -32768);  // other diagonal
    send_segment(100, 100, 104, 103);            // within tolerance, dropped
    send_segment(200, 200, 200, 200);            // single point
    send_segment(0, 100, 200, 100);              // start on the left edge
    send_segment(448, 384, 300, 300);            // start on the top right corner
  endtask

  task automatic test_special_cases();
    // zero tolerance acts as one
    program_window(0, 0, 448, 384, 0);
    send_segment(10, 10, 11, 11);
    send_segment(10, 10, 300, 200);
    send_segment(-50, 50, 300, 60);
    // bit above the tolerance field is ignored
    program_window(0, 0, 448, 384, 16'h8003);
    send_segment(-300, -200, 700, 600);
    // inverted window marks every point outside
    program_window(300, 250, 100, 50, 4);
    send_segment(-1000, 50, 1000, 60);
    send_segment(200, 150, 210, 140);
    // wide window, tolerance one: deep subdivision, stack and fragment limits
    program_window(-32000, -32000, 32000, 32000, 1);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(-32768, 5, 32767, -7);
    send_segment(32767, 0, -32768, 1);
    // thin strip near one end of the range
    program_window(32700, -32768, 32767, 32767, 1);
    send_segment(-32768, 0, 32767, 3);
    send_segment(32767, 1000, 32701, -1000);
  endtask

  task automatic test_register_extremes();
    // widest window, widest tolerance
    program_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32767);
    send_segment(-32767, -32767, 32766, 32766);
    send_segment(-32768, 0, 32767, 0);
    send_segment(-100, -100, 100, 100);
    // fully inverted extremes, tolerance one
    program_window(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(0, 0, 1000, -1000);
  endtask

  // random windows with idling on both sides
  task automatic test_random_windows();
    for (int phase = 0; phase < 4; phase++) begin
      random_window();
      for (int i = 0; i < 65; i++) begin
        send_random_segment();
        // hold the sender once until the block has delivered everything
        if (phase == 1 && i == 30) wait_for_results();
      end
    end
  endtask

  // closing stretch at full rate, no gaps and no stalls
  task automatic test_random_full_rate();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_window();
    for (int i = 0; i < 60; i++) send_random_segment();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_window();
    test_special_cases();
    test_register_extremes();
    test_random_windows();
    test_random_full_rate();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_pieces.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, awaited_pieces.size());
    $display("clipped %0d segments under %0d window settings (%0d register writes)",
             segments_sent, windows_set, writes_done);
    $display("checked %0d results: %0d fragments, %0d empty markers, %0d cut short",
             results_seen, fragments_seen, markers_seen, cuts_seen);
    if (errors == 0 && awaited_pieces.size() == 0) begin
      $display("midpoint_subdivision_line_clipper_tb OK");
    end else begin
      $display("midpoint_subdivision_line_clipper_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mslc_pkg.sv
hdl/mslc_ram.sv
hdl/mslc_datapath.sv
hdl/mslc_ctrl.sv
hdl/midpoint_subdivision_line_clipper.sv
tb/midpoint_subdivision_line_clipper_tb.sv
